### rtl/core/pid_sc_pkg.sv
package pid_sc_pkg;

  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned DefDataWidth = 32;
  localparam int unsigned DefFracBits  = 16;
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic signed [FieldWidth-1:0] GainRst    = '0;
  localparam logic signed [FieldWidth-1:0] LowLimRst  = {1'b1, {(FieldWidth-1){1'b0}}};
  localparam logic signed [FieldWidth-1:0] HighLimRst = {1'b0, {(FieldWidth-1){1'b1}}};

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INTEGRAL_LOW,
    REG_INTEGRAL_HIGH,
    REG_DRIVE_LOW,
    REG_DRIVE_HIGH
  } cfg_reg_e;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### rtl/core/pid_step_clamped_core.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o    action_i, error_sample_i, time_step_i
// out       output     out_valid_o / out_ready_i  drive_o, bad_step_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// an update item runs through the three serial gain multipliers, then load, then the serial
// derivative divider with the time step multiplier beside it, then accumulate, sum, clamp
// and the output register
// a clear item or a zero time step goes straight from idle to the output register
// one item at a time; the next item is taken while the result waits in the output register
// reset clears gains to 0, limits to full range, integral and last error to 0
// a stalled output holds the sequencer before it returns to idle
module pid_step_clamped_core #(
  parameter int unsigned DATA_WIDTH = pid_sc_pkg::DefDataWidth,
  parameter int unsigned FRAC_BITS  = pid_sc_pkg::DefFracBits
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic                                      action_i,
  input  logic signed [pid_sc_pkg::FieldWidth-1:0]  error_sample_i,
  input  logic        [pid_sc_pkg::FieldWidth-1:0]  time_step_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [pid_sc_pkg::FieldWidth-1:0]  drive_o,
  output logic                                      bad_step_o,
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic        [pid_sc_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic        [pid_sc_pkg::FieldWidth-1:0]  cfg_data_i
);
  import pid_sc_pkg::*;

  localparam int unsigned SatBits = (DATA_WIDTH > 32) ? 32 :
                                    ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam int unsigned WideW   = 2 * FieldWidth + 2;
  localparam int unsigned SumW    = FieldWidth + 2;
  localparam int unsigned ProdW   = 2 * FieldWidth;
  localparam logic signed [WideW-1:0] SatMax = (WideW'(1) << (SatBits - 1)) - WideW'(1);
  localparam logic signed [WideW-1:0] SatMin = ~SatMax;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_SUM,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef logic signed [FieldWidth-1:0] word_t;

  function automatic word_t sat_w(input logic signed [WideW-1:0] x);
    word_t r;
    if (x > SatMax) begin
      r = SatMax[FieldWidth-1:0];
    end else if (x < SatMin) begin
      r = SatMin[FieldWidth-1:0];
    end else begin
      r = x[FieldWidth-1:0];
    end
    return r;
  endfunction

  // upper limit is checked first; with crossed limits a value above it gets it, all else the lower
  function automatic word_t limit(input word_t v, input word_t lo, input word_t hi);
    word_t r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  state_e state_q, state_d;

  word_t gain_p_q, gain_p_d, gain_i_q, gain_i_d, gain_d_q, gain_d_d;
  word_t int_lo_q, int_lo_d, int_hi_q, int_hi_d;
  word_t drv_lo_q, drv_lo_d, drv_hi_q, drv_hi_d;
  word_t integ_q, integ_d, last_err_q, last_err_d;
  logic  out_valid_q, out_valid_d;

  word_t                 err_q, err_d;
  logic [FieldWidth-1:0] dt_q, dt_d;
  word_t                 prop_q, prop_d, ipart1_q, ipart1_d, ipart_q, ipart_d;
  word_t                 deriv_q, deriv_d, res_q, res_d, out_drive_q, out_drive_d;
  logic                  res_bad_q, res_bad_d, out_bad_q, out_bad_d;
  logic                  dneg_q, dneg_d;
  logic [ProdW-1:0]      dmag_q, dmag_d;
  logic signed [SumW-1:0] sum_q, sum_d;

  word_t err_sat, diff;
  logic  mul_start, unit2_start;

  logic signed [ProdW-1:0] prod_p, prod_i, prod_d;
  logic signed [ProdW:0]   prod_t;
  logic [ProdW-1:0]        quot;
  logic signed [WideW-1:0] quot_ext;
  unit_stat_t              mul_p_stat, mul_i_stat, mul_d_stat, mul_t_stat, div_stat;

  assign err_sat  = sat_w(WideW'(error_sample_i));
  assign diff     = sat_w(WideW'(err_sat) - WideW'(last_err_q));
  assign quot_ext = $signed({2'b00, quot});

  pid_sc_mul #(.AW(FieldWidth), .BW(FieldWidth)) u_mul_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (gain_p_q),
    .b_i     (err_sat),
    .prod_o  (prod_p),
    .stat_o  (mul_p_stat)
  );

  pid_sc_mul #(.AW(FieldWidth), .BW(FieldWidth)) u_mul_i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (gain_i_q),
    .b_i     (err_sat),
    .prod_o  (prod_i),
    .stat_o  (mul_i_stat)
  );

  pid_sc_mul #(.AW(FieldWidth), .BW(FieldWidth)) u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (gain_d_q),
    .b_i     (diff),
    .prod_o  (prod_d),
    .stat_o  (mul_d_stat)
  );

  pid_sc_mul #(.AW(FieldWidth), .BW(FieldWidth + 1)) u_mul_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit2_start),
    .a_i     (ipart1_q),
    .b_i     ($signed({1'b0, dt_q})),
    .prod_o  (prod_t),
    .stat_o  (mul_t_stat)
  );

  pid_sc_div #(.NW(ProdW), .DW(FieldWidth)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit2_start),
    .dividend_i (dmag_q),
    .divisor_i  (dt_q),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    gain_p_d    = gain_p_q;
    gain_i_d    = gain_i_q;
    gain_d_d    = gain_d_q;
    int_lo_d    = int_lo_q;
    int_hi_d    = int_hi_q;
    drv_lo_d    = drv_lo_q;
    drv_hi_d    = drv_hi_q;
    integ_d     = integ_q;
    last_err_d  = last_err_q;
    out_valid_d = out_valid_q;
    err_d       = err_q;
    dt_d        = dt_q;
    prop_d      = prop_q;
    ipart1_d    = ipart1_q;
    ipart_d     = ipart_q;
    deriv_d     = deriv_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    sum_d       = sum_q;
    res_d       = res_q;
    res_bad_d   = res_bad_q;
    out_drive_d = out_drive_q;
    out_bad_d   = out_bad_q;
    mul_start   = 1'b0;
    unit2_start = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN_P:        gain_p_d = cfg_data_i;
        REG_GAIN_I:        gain_i_d = cfg_data_i;
        REG_GAIN_D:        gain_d_d = cfg_data_i;
        REG_INTEGRAL_LOW:  int_lo_d = cfg_data_i;
        REG_INTEGRAL_HIGH: int_hi_d = cfg_data_i;
        REG_DRIVE_LOW:     drv_lo_d = cfg_data_i;
        REG_DRIVE_HIGH:    drv_hi_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          err_d = err_sat;
          dt_d  = time_step_i;
          if (action_i) begin
            integ_d    = '0;
            last_err_d = '0;
            res_d      = '0;
            res_bad_d  = 1'b0;
            state_d    = ST_OUT;
          end else if (time_step_i == '0) begin
            res_d     = '0;
            res_bad_d = 1'b1;
            state_d   = ST_OUT;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_p_stat.done && mul_i_stat.done && mul_d_stat.done) begin
          prop_d   = sat_w(WideW'(prod_p >>> FRAC_BITS));
          ipart1_d = sat_w(WideW'(prod_i >>> FRAC_BITS));
          dneg_d   = prod_d[ProdW-1];
          dmag_d   = prod_d[ProdW-1] ? $unsigned(-prod_d) : $unsigned(prod_d);
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        unit2_start = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (!mul_t_stat.busy && !div_stat.busy) begin
          ipart_d = sat_w(WideW'(prod_t >>> FRAC_BITS));
          deriv_d = dneg_q ? sat_w(-quot_ext) : sat_w(quot_ext);
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        integ_d = limit(sat_w(WideW'(integ_q) + WideW'(ipart_q)), int_lo_q, int_hi_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_d      = SumW'(prop_q) + SumW'(integ_q) + SumW'(deriv_q);
        last_err_d = err_q;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        res_d     = limit(sat_w(WideW'(sum_q)), drv_lo_q, drv_hi_q);
        res_bad_d = 1'b0;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_drive_d = res_q;
          out_bad_d   = res_bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_p_q    <= GainRst;
      gain_i_q    <= GainRst;
      gain_d_q    <= GainRst;
      int_lo_q    <= LowLimRst;
      int_hi_q    <= HighLimRst;
      drv_lo_q    <= LowLimRst;
      drv_hi_q    <= HighLimRst;
      integ_q     <= '0;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
      out_drive_q <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_p_q    <= gain_p_d;
      gain_i_q    <= gain_i_d;
      gain_d_q    <= gain_d_d;
      int_lo_q    <= int_lo_d;
      int_hi_q    <= int_hi_d;
      drv_lo_q    <= drv_lo_d;
      drv_hi_q    <= drv_hi_d;
      integ_q     <= integ_d;
      last_err_q  <= last_err_d;
      out_valid_q <= out_valid_d;
      out_drive_q <= out_drive_d;
      out_bad_q   <= out_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q       <= err_d;
    dt_q        <= dt_d;
    prop_q      <= prop_d;
    ipart1_q    <= ipart1_d;
    ipart_q     <= ipart_d;
    deriv_q     <= deriv_d;
    dneg_q      <= dneg_d;
    dmag_q      <= dmag_d;
    sum_q       <= sum_d;
    res_q       <= res_d;
    res_bad_q   <= res_bad_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign bad_step_o  = out_bad_q;

  // a skipped step never carries a drive value
  a_bad_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_step_o |-> drive_o == '0)
    else $error("bad step item with nonzero drive");

  // clear leaves the controller state at zero
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i |=> integ_q == '0 && last_err_q == '0)
    else $error("clear did not zero the state");

  // with ordered limits the integral lands inside them
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC && int_lo_q <= int_hi_q |=> integ_q >= int_lo_q && integ_q <= int_hi_q)
    else $error("integral outside its limits");

  // second phase units and the proportional multiplier are quiet whenever the sequencer is idle
  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !div_stat.busy && !mul_t_stat.busy && !mul_p_stat.busy)
    else $error("arithmetic unit busy while idle");

endmodule

### rtl/core/pid_sc_mul.sv
module pid_sc_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  output logic signed [AW+BW-1:0]   prod_o,
  output pid_sc_pkg::unit_stat_t    stat_o
);
  import pid_sc_pkg::*;

  localparam int unsigned CntW = (BW > 1) ? $clog2(BW) : 1;

  logic signed [AW-1:0] a_q;
  logic signed [AW:0]   hi_q, hi_d, addend, sum;
  logic [BW-1:0]        lo_q, lo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 last;

  // one multiplier bit per cycle, the sign bit weighs negative
  always_comb begin
    last   = (cnt_q == CntW'(BW - 1));
    addend = lo_q[0] ? {a_q[AW-1], a_q} : '0;
    sum    = last ? (hi_q - addend) : (hi_q + addend);
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum >>> 1;
      lo_d  = {sum[0], lo_q[BW-1:1]};
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign prod_o      = $signed({hi_q[AW-1:0], lo_q});
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/core/pid_sc_div.sv
module pid_sc_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NW-1:0]          dividend_i,
  input  logic [DW-1:0]          divisor_i,
  output logic [NW-1:0]          quot_o,
  output pid_sc_pkg::unit_stat_t stat_o
);
  import pid_sc_pkg::*;

  localparam int unsigned CntW = (NW > 1) ? $clog2(NW) : 1;

  logic [DW-1:0]   rem_q, rem_d, dvs_q;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW:0]     shifted, trial;
  logic            ge;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic            last;

  // restoring division, one quotient bit per cycle
  always_comb begin
    last    = (cnt_q == CntW'(NW - 1));
    shifted = {rem_q, quo_q[NW-1]};
    trial   = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[DW-1:0] : shifted[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quot_o      = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
